// ===== src/xcfp_pkg.sv =====
package xcfp_pkg;

	// Frame layout.
	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned LENGTH_POS   = 4;

	localparam int unsigned POS_W  = 9;
	localparam int unsigned BYTE_W = 8;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Result kinds.
	localparam logic [1:0] KIND_MORE  = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_READY = 2'd2;

	// Sticky error codes.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SYNC     = 2'd1;
	localparam logic [1:0] ERR_VERSION  = 2'd2;
	localparam logic [1:0] ERR_CHECKSUM = 2'd3;

	// Register indexes.
	localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
	localparam logic [1:0] REG_VERSION_VALUE = 2'd2;

	localparam int unsigned ADDR_W = 4;

	typedef struct packed {
		byte_t sync_first;
		byte_t sync_second;
		byte_t version_value;
	} cfg_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] last_error;
		byte_t      echo_byte;
		pos_t       byte_offset;
		byte_t      payload_length;
	} result_t;

endpackage

// ===== src/xcfp_if.sv =====
interface xcfp_byte_if;
	import xcfp_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface xcfp_result_if;
	import xcfp_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [1:0] last_error;
	byte_t      echo_byte;
	pos_t       byte_offset;
	byte_t      payload_length;
	modport source (output valid, output result_kind, output last_error, output echo_byte,
		output byte_offset, output payload_length, input ready);
	modport sink (input valid, input result_kind, input last_error, input echo_byte,
		input byte_offset, input payload_length, output ready);
endinterface

// ===== src/xcfp_cfg_regs.sv =====
module xcfp_cfg_regs
	import xcfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_FIRST:    cfg_q.sync_first    <= pwdata[BYTE_W-1:0];
				REG_SYNC_SECOND:   cfg_q.sync_second   <= pwdata[BYTE_W-1:0];
				REG_VERSION_VALUE: cfg_q.version_value <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYNC_FIRST:    prdata = {24'd0, cfg_q.sync_first};
			REG_SYNC_SECOND:   prdata = {24'd0, cfg_q.sync_second};
			REG_VERSION_VALUE: prdata = {24'd0, cfg_q.version_value};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/xcfp_engine.sv =====
module xcfp_engine
	import xcfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  byte_t   data_byte,
	output result_t result
);

	// Parser state.
	pos_t       pos_q;
	pos_t       total_q;
	byte_t      xor_q;
	byte_t      len_q;
	logic       done_q;
	logic [1:0] err_q;

	pos_t       off;
	pos_t       tot_cur;
	pos_t       pos_nxt;
	pos_t       tot_nxt;
	byte_t      prior_xor;
	byte_t      xor_nxt;
	byte_t      len_nxt;
	logic       done_nxt;
	logic [1:0] err_nxt;
	logic [1:0] kind;
	pos_t       pos_inc;
	pos_t       tot_calc;
	logic       hdr_fail;
	logic [1:0] hdr_code;

	always_comb begin
		// A finished frame means this byte starts a new one.
		off     = done_q ? '0 : pos_q;
		tot_cur = done_q ? '0 : total_q;

		hdr_fail = 1'b0;
		hdr_code = ERR_NONE;
		if (off == pos_t'(0) && data_byte != cfg.sync_first) begin
			hdr_fail = 1'b1;
			hdr_code = ERR_SYNC;
		end else if (off == pos_t'(1) && data_byte != cfg.sync_second) begin
			hdr_fail = 1'b1;
			hdr_code = ERR_SYNC;
		end else if (off == pos_t'(2) && data_byte != cfg.version_value) begin
			hdr_fail = 1'b1;
			hdr_code = ERR_VERSION;
		end

		prior_xor = (off == '0) ? '0 : xor_q;
		pos_inc   = off + pos_t'(1);
		len_nxt   = (off == pos_t'(LENGTH_POS)) ? data_byte : len_q;
		tot_calc  = pos_t'(HEADER_BYTES) + {1'b0, len_nxt} + pos_t'(1);

		if (hdr_fail) begin
			// The failing byte leaves checksum and length untouched.
			xor_nxt  = xor_q;
			len_nxt  = len_q;
			pos_nxt  = '0;
			tot_nxt  = '0;
			done_nxt = 1'b0;
			err_nxt  = hdr_code;
			kind     = KIND_ERROR;
		end else begin
			xor_nxt  = prior_xor ^ data_byte;
			pos_nxt  = pos_inc;
			tot_nxt  = (pos_inc == pos_t'(HEADER_BYTES)) ? tot_calc : tot_cur;
			done_nxt = 1'b0;
			err_nxt  = err_q;
			if (tot_nxt == '0 || pos_inc < tot_nxt) begin
				kind = KIND_MORE;
			end else if (data_byte != prior_xor) begin
				kind    = KIND_ERROR;
				err_nxt = ERR_CHECKSUM;
				pos_nxt = '0;
				tot_nxt = '0;
			end else begin
				kind     = KIND_READY;
				done_nxt = 1'b1;
			end
		end

		result.result_kind    = kind;
		result.last_error     = err_nxt;
		result.echo_byte      = data_byte;
		result.byte_offset    = off;
		result.payload_length = (tot_nxt != '0) ? len_nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			total_q <= '0;
			xor_q   <= '0;
			len_q   <= '0;
			done_q  <= 1'b0;
			err_q   <= ERR_NONE;
		end else if (step) begin
			pos_q   <= pos_nxt;
			total_q <= tot_nxt;
			xor_q   <= xor_nxt;
			len_q   <= len_nxt;
			done_q  <= done_nxt;
			err_q   <= err_nxt;
		end
	end

endmodule

// ===== src/xor_checked_frame_parser_unit.sv =====
// Byte-serial frame parser with an XOR checksum.
// Input channel rx carries one received byte per beat; output channel res carries
// one result beat per input byte: the result kind (need more, error, frame ready),
// the sticky last error code, the byte echoed, its offset within the frame and the
// payload length once the header is complete.
// The three match registers (first sync byte, second sync byte, version) are
// written over the APB port at byte addresses 0, 4 and 8, by the user only while
// the block is idle; the block itself does not enforce this. An accepted byte is
// first captured in an input register, then the parser state update and the
// result are computed in one pass and stored in the result register.
// Throughput is one byte per cycle while the receiver does not stall, as the
// position counter and running XOR are updated in one pass per byte.
// When the receiver stalls, the result register holds, the input register fills,
// and rx.ready drops only once both are occupied.
// Reset clears the match registers, the parser state and the sticky error, and
// empties both pipeline registers.
module xor_checked_frame_parser_unit
	import xcfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	xcfp_byte_if.sink         rx,
	xcfp_result_if.source     res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg;
	result_t step_res;
	result_t res_q;
	logic    res_vld_q;
	logic    in_vld_s1;
	byte_t   in_byte_s1;
	logic    advance;

	xcfp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The byte in the input register is processed whenever the result register
	// is free or is being drained in this cycle.
	assign advance  = in_vld_s1 & (~res_vld_q | res.ready);
	assign rx.ready = ~in_vld_s1 | advance;

	xcfp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.data_byte (in_byte_s1),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			in_vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			in_byte_s1 <= rx.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.result_kind    = res_q.result_kind;
	assign res.last_error     = res_q.last_error;
	assign res.echo_byte      = res_q.echo_byte;
	assign res.byte_offset    = res_q.byte_offset;
	assign res.payload_length = res_q.payload_length;

	// An error result always carries a nonzero error code and no payload length.
	a_err_coded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.result_kind == KIND_ERROR) |->
		(res_q.last_error != ERR_NONE && res_q.payload_length == '0))
		else $error("error result without error code or with a length");

	// A ready frame ends at an offset past the header.
	a_ready_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.result_kind == KIND_READY) |->
		(res_q.byte_offset >= pos_t'(HEADER_BYTES)))
		else $error("frame ready inside the header");

	// With both registers full and the receiver stalled, no new byte is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld_s1 && res_vld_q && !res.ready) |-> !rx.ready)
		else $error("input taken while pipeline is full");

	// A processed byte always produces a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_vld_q)
		else $error("processed byte produced no result");

endmodule

// ===== tb/xor_checked_frame_parser_unit_tb.sv =====
module xor_checked_frame_parser_unit_tb;
	import xcfp_pkg::*;

	// Kinds of damage that the frame generator can put into an otherwise good frame.
	localparam int unsigned FLAW_NONE        = 0;
	localparam int unsigned FLAW_SYNC_FIRST  = 1;
	localparam int unsigned FLAW_SYNC_SECOND = 2;
	localparam int unsigned FLAW_VERSION     = 3;
	localparam int unsigned FLAW_CHECKSUM    = 4;
	localparam int unsigned FLAW_TRUNCATE    = 5;

	localparam int unsigned PHASES        = 5;
	localparam int unsigned PHASE_BYTES   = 70;
	localparam int unsigned QUIET_PHASE   = 2;
	localparam int unsigned RANDOM_PHASE  = 3;
	localparam int unsigned DRAIN_CYCLES  = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	xcfp_byte_if   rx_if ();
	xcfp_result_if res_if ();

	xor_checked_frame_parser_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// One row of the directed part. Where typed is set, want holds the result read
	// straight off the frame rules; otherwise the parser prediction is used.
	typedef struct {
		byte_t   data;
		bit      typed;
		result_t want;
	} probe_t;

	// The directed rows run with the reset register values, so every match byte is zero.
	probe_t directed_rows [20] = '{
		// A nonzero first byte is a bad sync; the byte is dropped.
		'{8'hFF, 1'b1, '{KIND_ERROR, ERR_SYNC, 8'hFF, 9'd0, 8'd0}},
		// The sticky code survives a good byte.
		'{8'h00, 1'b1, '{KIND_MORE, ERR_SYNC, 8'h00, 9'd0, 8'd0}},
		// Bad second sync byte.
		'{8'h80, 1'b1, '{KIND_ERROR, ERR_SYNC, 8'h80, 9'd1, 8'd0}},
		'{8'h00, 1'b1, '{KIND_MORE, ERR_SYNC, 8'h00, 9'd0, 8'd0}},
		'{8'h00, 1'b1, '{KIND_MORE, ERR_SYNC, 8'h00, 9'd1, 8'd0}},
		// Wrong version byte.
		'{8'h01, 1'b1, '{KIND_ERROR, ERR_VERSION, 8'h01, 9'd2, 8'd0}},
		// A frame with an empty payload and a good checksum.
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h5A, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h5A, 1'b1, '{KIND_READY, ERR_VERSION, 8'h5A, 9'd5, 8'd0}},
		// The byte after a finished frame starts a new one; this one carries one
		// payload byte and a wrong checksum.
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'hAA, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_ERROR, ERR_CHECKSUM, 8'h00, 9'd6, 8'd0}},
		// Back at offset zero with a byte that the sync check rejects.
		'{8'h12, 1'b0, '0}
	};

	// Match values for the random phases. The phase marked random gets fresh values.
	cfg_t phase_cfgs [PHASES] = '{
		'{8'hFF, 8'hFF, 8'hFF},
		'{8'hA5, 8'h5A, 8'h01},
		'{8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00},
		'{8'h00, 8'hFF, 8'h80}
	};

	// Parser prediction state, kept in step with every accepted beat.
	cfg_t        shadow_cfg;
	pos_t        at_pos;
	pos_t        frame_size;
	byte_t       xor_acc;
	byte_t       len_byte;
	logic        frame_closed;
	logic [1:0]  sticky_err;

	result_t     due_results [$];
	int unsigned mismatch_count;
	int unsigned sent_bytes;
	int unsigned gap_pct;
	int unsigned stall_pct;

	// Clock with a period of 10 time units.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic void restart_prediction();
		at_pos       = '0;
		frame_size   = '0;
		frame_closed = 1'b0;
	endfunction

	// Works out the result beat caused by one accepted byte and advances the parser
	// state. A running XOR over the frame stands in for a frame buffer.
	function automatic result_t parse_byte(input byte_t b);
		result_t    r;
		pos_t       off;
		byte_t      prior;
		logic [1:0] kind;

		if (frame_closed)
			restart_prediction();
		off = at_pos;
		if (off == 0 && b != shadow_cfg.sync_first) begin
			sticky_err = ERR_SYNC;
			restart_prediction();
			kind = KIND_ERROR;
		end else if (off == 1 && b != shadow_cfg.sync_second) begin
			sticky_err = ERR_SYNC;
			restart_prediction();
			kind = KIND_ERROR;
		end else if (off == 2 && b != shadow_cfg.version_value) begin
			sticky_err = ERR_VERSION;
			restart_prediction();
			kind = KIND_ERROR;
		end else begin
			prior   = (off == 0) ? '0 : xor_acc;
			xor_acc = prior ^ b;
			if (off == LENGTH_POS)
				len_byte = b;
			at_pos = off + 1'b1;
			// The frame size is only known once the whole header has been seen.
			if (at_pos == HEADER_BYTES)
				frame_size = pos_t'(HEADER_BYTES + len_byte + 1);
			if (frame_size == 0 || at_pos < frame_size) begin
				kind = KIND_MORE;
			end else if (b != prior) begin
				sticky_err = ERR_CHECKSUM;
				restart_prediction();
				kind = KIND_ERROR;
			end else begin
				frame_closed = 1'b1;
				kind = KIND_READY;
			end
		end
		r.result_kind    = kind;
		r.last_error     = sticky_err;
		r.echo_byte      = b;
		r.byte_offset    = off;
		r.payload_length = (frame_size != 0) ? len_byte : '0;
		return r;
	endfunction

	// Offers one byte on the rx channel, idling first at random, and queues the result
	// due for it once the beat is accepted. Called right after a rising edge.
	task automatic send_byte(input byte_t b, input bit typed = 1'b0, input result_t want = '0);
		result_t predicted;

		while ($urandom_range(0, 99) < gap_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid     <= 1'b1;
		rx_if.data_byte <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		// The beat was taken at this edge; the prediction must run even when the
		// expected result is typed in, so that the parser state stays in step.
		predicted = parse_byte(b);
		due_results.push_back(typed ? want : predicted);
		sent_bytes++;
	endtask

	// Sends one frame built for the current match values, with an optional flaw.
	task automatic send_frame(input int unsigned len, input int unsigned flaw);
		byte_t       frame_xor;
		byte_t       b;
		int unsigned total;
		int unsigned stop_at;

		frame_xor = '0;
		total     = HEADER_BYTES + len + 1;
		stop_at   = (flaw == FLAW_TRUNCATE) ? $urandom_range(1, total - 1) : total;
		for (int unsigned i = 0; i < stop_at; i++) begin
			if (i == 0)
				b = shadow_cfg.sync_first;
			else if (i == 1)
				b = shadow_cfg.sync_second;
			else if (i == 2)
				b = shadow_cfg.version_value;
			else if (i == LENGTH_POS)
				b = byte_t'(len);
			else if (i == total - 1)
				b = frame_xor;
			else
				b = byte_t'($urandom);
			if ((flaw == FLAW_SYNC_FIRST && i == 0) || (flaw == FLAW_SYNC_SECOND && i == 1) ||
				(flaw == FLAW_VERSION && i == 2) || (flaw == FLAW_CHECKSUM && i == total - 1))
				b ^= byte_t'($urandom_range(1, 255));
			frame_xor ^= b;
			send_byte(b);
		end
	endtask

	// Writes one match register over the APB port and reads it back. The read setup
	// follows the write access directly, so psel stays high between them.
	task automatic write_reg(input logic [1:0] idx, input byte_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SYNC_FIRST: begin
				shadow_cfg.sync_first = value;
			end
			REG_SYNC_SECOND: begin
				shadow_cfg.sync_second = value;
			end
			REG_VERSION_VALUE: begin
				shadow_cfg.version_value = value;
			end
			default: begin
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[7:0] !== value)
			report_mismatch("register readback", prdata[7:0], value);
		psel    <= 1'b0;
		penable <= 1'b0;
		// The bus goes idle before the next transfer.
		@(posedge clk);
	endtask

	// Waits until every queued result has been delivered, then lets the pipeline settle.
	task automatic drain_results();
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: stalls at random and compares each accepted beat, field by field,
	// with the oldest result due. Values sampled here are those from before the edge.
	always @(posedge clk) begin
		result_t want;

		if (arst_n && res_if.valid && res_if.ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result beat with none due", res_if.echo_byte, 0);
			end else begin
				want = due_results.pop_front();
				if (res_if.result_kind !== want.result_kind)
					report_mismatch("result_kind", res_if.result_kind, want.result_kind);
				if (res_if.last_error !== want.last_error)
					report_mismatch("last_error", res_if.last_error, want.last_error);
				if (res_if.echo_byte !== want.echo_byte)
					report_mismatch("echo_byte", res_if.echo_byte, want.echo_byte);
				if (res_if.byte_offset !== want.byte_offset)
					report_mismatch("byte_offset", res_if.byte_offset, want.byte_offset);
				if (res_if.payload_length !== want.payload_length)
					report_mismatch("payload_length", res_if.payload_length,
						want.payload_length);
			end
		end
		res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Main sequence: reset, the directed rows, then several phases of random frames,
	// each under its own match values and written while the parser is idle.
	initial begin
		int unsigned phase_end;
		int unsigned pick;
		int unsigned len;

		mismatch_count  = 0;
		sent_bytes      = 0;
		gap_pct         = 33;
		stall_pct       = 33;
		shadow_cfg      = '0;
		xor_acc         = '0;
		len_byte        = '0;
		sticky_err      = ERR_NONE;
		restart_prediction();

		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.data_byte = '0;
		res_if.ready    = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

		for (int unsigned p = 0; p < PHASES; p++) begin
			rx_if.valid <= 1'b0;
			drain_results();
			if (p == RANDOM_PHASE)
				phase_cfgs[p] = cfg_t'($urandom);
			write_reg(REG_SYNC_FIRST, phase_cfgs[p].sync_first);
			write_reg(REG_SYNC_SECOND, phase_cfgs[p].sync_second);
			write_reg(REG_VERSION_VALUE, phase_cfgs[p].version_value);
			@(posedge clk);

			// One phase runs with neither side idling at all.
			gap_pct   = (p == QUIET_PHASE) ? 0 : 33;
			stall_pct = (p == QUIET_PHASE) ? 0 : 33;

			// The first phase opens with the longest frame the length byte allows.
			if (p == 0)
				send_frame(255, FLAW_NONE);

			phase_end = sent_bytes + PHASE_BYTES;
			while (sent_bytes < phase_end) begin
				pick = $urandom_range(0, 99);
				len  = ($urandom_range(0, 99) < 5) ? $urandom_range(16, 60) : $urandom_range(0, 12);
				if (pick < 70) begin
					send_frame(len, FLAW_NONE);
				end else if (pick < 85) begin
					send_frame(len, $urandom_range(FLAW_SYNC_FIRST, FLAW_TRUNCATE));
				end else begin
					// Line noise, sometimes made of match values so that partial
					// headers appear.
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1))
							send_byte(byte_t'($urandom));
						else
							send_byte($urandom_range(0, 1) ? shadow_cfg.sync_first
								: shadow_cfg.sync_second);
					end
				end
			end
		end

		rx_if.valid <= 1'b0;
		drain_results();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: the whole run needs far fewer cycles than this.
	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
src/xcfp_pkg.sv
src/xcfp_if.sv
src/xcfp_cfg_regs.sv
src/xcfp_engine.sv
src/xor_checked_frame_parser_unit.sv
tb/xor_checked_frame_parser_unit_tb.sv
